// ===== design/assert_macros.svh =====
// Assertion macros shared by the radix integer to ASCII converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RITOA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define RITOA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ritoa_pkg.sv =====
// Package with shared types, constants and helpers of the integer to ASCII converter.
`default_nettype none

package ritoa_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int DIGIT_DEPTH_DEFAULT = 32;

   // Dividend bits consumed by the digit divider in one cycle.
   localparam int STEP_BITS = 8;
   localparam int BASE_WIDTH = 5;
   localparam int FLAGS_WIDTH = 2;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH = 8;

   localparam logic [BASE_WIDTH-1:0] BASE_MIN = 5'd2;
   localparam logic [BASE_WIDTH-1:0] BASE_MAX = 5'd16;

   localparam int FLAG_LOWER = 0;
   localparam int FLAG_UNSIGNED = 1;

   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] ASCII_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PREP,
      ST_EMIT
   } ritoa_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last_chunk;
      logic prep;
      logic emit;
   } ritoa_cmd_type;

   typedef struct packed {
      logic div_done;
      logic idx_zero;
   } ritoa_status_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [DIGIT_WIDTH-1:0] digit,
                                                       input logic lower);
      logic [CHAR_WIDTH-1:0] result;
      if (digit < 4'd10) begin
         result = ASCII_ZERO + CHAR_WIDTH'(digit);
      end else if (lower) begin
         result = ASCII_LOWER_A + CHAR_WIDTH'(digit - 4'd10);
      end else begin
         result = ASCII_UPPER_A + CHAR_WIDTH'(digit - 4'd10);
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/ritoa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ritoa_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== design/ritoa_datapath.sv =====
// Datapath: digit divider, digit stack addressing and character output register.
`default_nettype none
`include "assert_macros.svh"

module ritoa_datapath #(
   parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGIT_DEPTH = ritoa_pkg::DIGIT_DEPTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire ritoa_pkg::ritoa_cmd_type                cmd,
   output ritoa_pkg::ritoa_status_type                  status,
   input  wire logic signed [VALUE_WIDTH-1:0]           req_value,
   input  wire logic [ritoa_pkg::BASE_WIDTH-1:0]        req_base,
   input  wire logic [ritoa_pkg::FLAGS_WIDTH-1:0]       req_format_flags,
   output logic                                         rsp_strobe,
   output logic [ritoa_pkg::CHAR_WIDTH-1:0]             rsp_character,
   output logic                                         rsp_last
);
   import ritoa_pkg::*;

   localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PW = CHUNKS * STEP_BITS;
   localparam int AW = $clog2(DIGIT_DEPTH);
   localparam int CNTW = $clog2(DIGIT_DEPTH + 1);

   logic [PW-1:0]          work_ff, work_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [BASE_WIDTH-1:0]  base_ff, base_in;
   logic                   lower_ff, lower_in;
   logic                   negative_ff, negative_in;
   logic [CNTW-1:0]        count_ff, count_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic                   strobe_ff, strobe_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;

   logic [VALUE_WIDTH-1:0] raw_value;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   is_negative;
   logic [STEP_BITS-1:0]   chunk;
   logic [STEP_BITS-1:0]   qbits;
   logic [DIGIT_WIDTH-1:0] rem_next;
   logic [PW-1:0]          quot_next;

   logic                   wr_en;
   logic [AW-1:0]          rd_addr;
   logic [DIGIT_WIDTH-1:0] rd_data;

   assign raw_value = req_value;
   assign is_negative = !req_format_flags[FLAG_UNSIGNED] && raw_value[VALUE_WIDTH-1];
   assign magnitude = is_negative ? (~raw_value + 1'b1) : raw_value;
   assign chunk = work_ff[PW-1 -: STEP_BITS];

   // Long division of the top dividend chunk by the base, one bit per step.
   always_comb begin
      logic [DIGIT_WIDTH:0] partial;
      logic [DIGIT_WIDTH-1:0] rem;
      rem = rem_ff;
      qbits = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         partial = {rem, chunk[i]};
         if (partial >= base_ff) begin
            qbits[i] = 1'b1;
            partial = partial - base_ff;
         end
         rem = partial[DIGIT_WIDTH-1:0];
      end
      rem_next = rem;
   end

   assign quot_next = (work_ff << STEP_BITS) | PW'(qbits);
   assign wr_en = cmd.step && cmd.last_chunk;

   assign status.div_done = (quot_next == '0) || (count_ff == CNTW'(DIGIT_DEPTH - 1));
   assign status.idx_zero = (idx_ff == '0);

   always_comb begin
      work_in = work_ff;
      rem_in = rem_ff;
      base_in = base_ff;
      lower_in = lower_ff;
      negative_in = negative_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      strobe_in = 1'b0;
      char_in = char_ff;
      last_in = last_ff;
      rd_addr = idx_ff - 1'b1;
      if (cmd.load) begin
         work_in = PW'(magnitude);
         rem_in = '0;
         if (req_base < BASE_MIN) begin
            base_in = BASE_MIN;
         end else if (req_base > BASE_MAX) begin
            base_in = BASE_MAX;
         end else begin
            base_in = req_base;
         end
         lower_in = req_format_flags[FLAG_LOWER];
         negative_in = is_negative;
         count_in = '0;
      end
      if (cmd.step) begin
         // After the last chunk the register holds the quotient for the next digit.
         work_in = quot_next;
         rem_in = cmd.last_chunk ? '0 : rem_next;
         if (cmd.last_chunk) begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.prep) begin
         strobe_in = negative_ff;
         char_in = ASCII_MINUS;
         last_in = 1'b0;
         rd_addr = AW'(count_ff - 1'b1);
         idx_in = AW'(count_ff - 1'b1);
      end
      if (cmd.emit) begin
         strobe_in = 1'b1;
         char_in = digit_char(rd_data, lower_ff);
         last_in = (idx_ff == '0);
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         count_ff <= '0;
         negative_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         count_ff <= count_in;
         negative_ff <= negative_in;
      end
      work_ff <= work_in;
      rem_ff <= rem_in;
      base_ff <= base_in;
      lower_ff <= lower_in;
      idx_ff <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   ritoa_ram #(
      .WIDTH(DIGIT_WIDTH),
      .DEPTH(DIGIT_DEPTH)
   ) u_stack (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(rem_next),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

   `RITOA_ASSERT(a_stack_push_in_range, wr_en |-> (count_ff < CNTW'(DIGIT_DEPTH)), "digit stack overflow")

endmodule

`default_nettype wire

// ===== design/ritoa_controller.sv =====
// Controller state machine sequencing division, sign output and digit output.
`default_nettype none
`include "assert_macros.svh"

module ritoa_controller #(
   parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire ritoa_pkg::ritoa_status_type status,
   output ritoa_pkg::ritoa_cmd_type         cmd
);
   import ritoa_pkg::*;

   localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

   ritoa_state_type state_ff, state_in;
   logic [CW-1:0]   chunk_ff, chunk_in;
   logic            at_last_chunk;

   assign at_last_chunk = (chunk_ff == LAST_CHUNK);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (at_last_chunk && status.div_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.idx_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      chunk_in = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            cmd.last_chunk = at_last_chunk;
            chunk_in = at_last_chunk ? '0 : chunk_ff + 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
      end
   end

   `RITOA_ASSERT_NEXT(a_start_enters_divide, start && !busy, state_ff == ST_DIVIDE, "accepted item did not start division")
   `RITOA_ASSERT(a_chunk_idle_outside_divide, (state_ff != ST_DIVIDE) |-> (chunk_ff == '0), "chunk counter active outside division")

endmodule

`default_nettype wire

// ===== design/radix_integer_to_ascii_top.sv =====
// Top level of the radix integer to ASCII converter.
//
// Usage: drive req_value, req_base and req_format_flags and raise start while
// busy is low; the item is taken at that clock edge. busy stays high until the
// last character of the number has been read from the digit stack. Characters
// appear on rsp_character, most significant first, one cycle each with
// rsp_strobe high; rsp_last marks the final character. A negative value in
// signed mode first gives a '-' character. The receiver cannot stall the
// output, so every strobed character must be taken in its cycle.
// Timing: the shared digit divider consumes 8 dividend bits per cycle and
// passes over all chunks of the value for each digit. busy stays high
// through division, the sign prep step and the output of every digit. The next
// item may start in the cycle in which the last character is on the output.
// Reset: synchronous and active high; it returns the controller to idle and
// drops the strobe. The digit stack needs no clearing.
`default_nettype none
`include "assert_macros.svh"

module radix_integer_to_ascii_top #(
   parameter int VALUE_WIDTH = ritoa_pkg::VALUE_WIDTH_DEFAULT,
   parameter int DIGIT_DEPTH = ritoa_pkg::DIGIT_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic signed [VALUE_WIDTH-1:0]        req_value,
   input  wire logic [ritoa_pkg::BASE_WIDTH-1:0]     req_base,
   input  wire logic [ritoa_pkg::FLAGS_WIDTH-1:0]    req_format_flags,
   output logic                                      rsp_strobe,
   output logic [ritoa_pkg::CHAR_WIDTH-1:0]          rsp_character,
   output logic                                      rsp_last
);
   import ritoa_pkg::*;

   ritoa_cmd_type    cmd;
   ritoa_status_type status;

   ritoa_controller #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_controller (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .status(status),
      .cmd(cmd)
   );

   ritoa_datapath #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DIGIT_DEPTH(DIGIT_DEPTH)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_value(req_value),
      .req_base(req_base),
      .req_format_flags(req_format_flags),
      .rsp_strobe(rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   // A new number cannot produce a character right after the previous one ends.
   `RITOA_ASSERT_NEXT(a_gap_after_last, rsp_strobe && rsp_last, !rsp_strobe, "character directly after last")

endmodule

`default_nettype wire

// ===== bench/radix_integer_to_ascii_top_test.sv =====
// Self-checking testbench for the radix integer to ASCII converter.
module radix_integer_to_ascii_top_test;
   import ritoa_pkg::*;

   localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
   localparam int DIGIT_DEPTH = DIGIT_DEPTH_DEFAULT;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } ascii_char_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value = '0;
   logic [BASE_WIDTH-1:0]  req_base = BASE_MIN;
   logic [FLAGS_WIDTH-1:0] req_format_flags = '0;
   logic                   rsp_strobe;
   logic [CHAR_WIDTH-1:0]  rsp_character;
   logic                   rsp_last;

   ascii_char_type expected_chars[$];
   int             error_count = 0;
   int             numbers_sent = 0;
   int             chars_checked = 0;

   radix_integer_to_ascii_top #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .DIGIT_DEPTH(DIGIT_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .req_base(req_base),
      .req_format_flags(req_format_flags),
      .rsp_strobe(rsp_strobe),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Appends the characters that one number must produce to the expected queue.
   function automatic void predict_characters(input logic [VALUE_WIDTH-1:0] value,
                                              input logic [BASE_WIDTH-1:0] base,
                                              input logic [FLAGS_WIDTH-1:0] flags);
      string                  lower_table;
      string                  upper_table;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [VALUE_WIDTH-1:0] radix;
      logic [DIGIT_WIDTH-1:0] digits[DIGIT_DEPTH];
      int                     count;
      logic                   negative;
      ascii_char_type         entry;
      lower_table = "0123456789abcdef";
      upper_table = "0123456789ABCDEF";
      radix = VALUE_WIDTH'(base);
      if (radix < VALUE_WIDTH'(BASE_MIN)) radix = VALUE_WIDTH'(BASE_MIN);
      if (radix > VALUE_WIDTH'(BASE_MAX)) radix = VALUE_WIDTH'(BASE_MAX);
      negative = !flags[FLAG_UNSIGNED] && value[VALUE_WIDTH-1];
      magnitude = negative ? (VALUE_WIDTH'(0) - value) : value;
      count = 0;
      do begin
         digits[count] = DIGIT_WIDTH'(magnitude % radix);
         count++;
         magnitude = magnitude / radix;
      end while (magnitude != 0 && count < DIGIT_DEPTH);
      if (negative) begin
         entry.character = ASCII_MINUS;
         entry.last = 1'b0;
         expected_chars.push_back(entry);
      end
      for (int k = count - 1; k >= 0; k--) begin
         entry.character = flags[FLAG_LOWER] ? lower_table[digits[k]] : upper_table[digits[k]];
         entry.last = (k == 0);
         expected_chars.push_back(entry);
      end
   endfunction

   // Offers one item, optionally after a random idle burst, and waits until it is taken.
   // start is left high so that a following item can go out without a gap.
   task automatic send_number(input logic [VALUE_WIDTH-1:0] value,
                              input logic [BASE_WIDTH-1:0] base,
                              input logic [FLAGS_WIDTH-1:0] flags,
                              input bit allow_idle);
      int gap;
      gap = 0;
      if (allow_idle && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_value <= value;
      req_base <= base;
      req_format_flags <= flags;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predict_characters(value, base, flags);
      numbers_sent++;
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected character, expected none actual %h last %b",
                     $time, rsp_character, rsp_last);
            error_count++;
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (rsp_character !== want.character) begin
               $display("%0t: character mismatch, expected %h actual %h",
                        $time, want.character, rsp_character);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $display("%0t: last flag mismatch, expected %b actual %b",
                        $time, want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // Zero, all-ones, both signed extremes, every flag combination and every radix.
   task automatic test_directed_extremes();
      send_number(32'd0, 5'd10, 2'b00, 1'b1);
      send_number(32'd0, 5'd2, 2'b11, 1'b1);
      send_number(32'hFFFF_FFFF, 5'd10, 2'b00, 1'b1);
      send_number(32'hFFFF_FFFF, 5'd16, 2'b10, 1'b1);
      send_number(32'hFFFF_FFFF, 5'd16, 2'b11, 1'b1);
      send_number(32'hFFFF_FFFF, 5'd2, 2'b10, 1'b1);
      // The most negative value in binary gives the longest output: a minus and 32 digits.
      send_number(32'h8000_0000, 5'd2, 2'b00, 1'b1);
      send_number(32'h8000_0000, 5'd10, 2'b01, 1'b1);
      send_number(32'h8000_0000, 5'd10, 2'b10, 1'b1);
      send_number(32'h7FFF_FFFF, 5'd10, 2'b00, 1'b1);
      send_number(32'h7FFF_FFFF, 5'd16, 2'b01, 1'b1);
      send_number(-32'sd171, 5'd16, 2'b01, 1'b1);
      for (int b = 2; b <= 16; b++) begin
         send_number(32'd123456789 ^ {32{b[0]}}, BASE_WIDTH'(b), FLAGS_WIDTH'(b), 1'b1);
      end
      wait_for_drain();
   endtask

   task automatic send_random_number(input bit allow_idle);
      logic [VALUE_WIDTH-1:0] value;
      case ($urandom_range(0, 4))
         0: value = $urandom();
         1: value = $urandom_range(0, 300);
         2: value = -$urandom_range(1, 300);
         3: value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                          : 32'h7FFF_FFFF - $urandom_range(0, 15);
         default: value = $urandom() >> $urandom_range(0, 31);
      endcase
      send_number(value, BASE_WIDTH'($urandom_range(2, 16)),
                  FLAGS_WIDTH'($urandom_range(0, 3)), allow_idle);
   endtask

   task automatic test_random_numbers();
      for (int i = 0; i < 300; i++) send_random_number(1'b1);
      wait_for_drain();
   endtask

   // Items follow each other with no idle cycles at all.
   task automatic test_back_to_back();
      for (int i = 0; i < 50; i++) send_random_number(1'b0);
      wait_for_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_random_numbers();
      test_back_to_back();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Converted %0d numbers into %0d characters, bases 2 to 16, all flag settings.",
               numbers_sent, chars_checked);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Timeout with %0d characters still expected.", expected_chars.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
